### hw/rtl/tgp_pkg.sv
// Shared constants for the touch gesture to pointer unit.
package tgp_pkg;

    // Input command codes
    localparam logic [1:0] CMD_DOWN   = 2'd0;
    localparam logic [1:0] CMD_UP     = 2'd1;
    localparam logic [1:0] CMD_MOTION = 2'd2;
    localparam logic [1:0] CMD_TICK   = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_MOVE     = 2'd0;
    localparam logic [1:0] KIND_BTN_DOWN = 2'd1;
    localparam logic [1:0] KIND_BTN_UP   = 2'd2;

    // Button masks
    localparam logic [1:0] BTN_NONE  = 2'd0;
    localparam logic [1:0] BTN_LEFT  = 2'd1;
    localparam logic [1:0] BTN_RIGHT = 2'd2;

    // Configuration register indexes and reset values
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_SLOP     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_MS = 1'd1;

    localparam int unsigned THR_W  = 8;
    localparam int unsigned LP_W   = 16;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned CMD_W  = 2;
    localparam int unsigned KIND_W = 2;
    localparam int unsigned BTN_W  = 2;

    localparam logic [THR_W-1:0] MOVE_SLOP_RST     = 8'd3;
    localparam logic [LP_W-1:0]  LONG_PRESS_MS_RST = 16'd500;

    // Results per input transaction
    localparam int unsigned MAX_RESULTS = 3;
    localparam int unsigned CNT_W       = 2;

endpackage

### hw/rtl/tgp_core.sv
// Gesture state and single-pass decode of one touch event into up to three results.
module tgp_core
    import tgp_pkg::*;
#(
    parameter int unsigned COORD_BITS = 10,
    parameter int unsigned TAG_BITS   = 8,
    parameter int unsigned DATA_W     = 48
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  logic [CMD_W-1:0]      cmd,
    input  logic [COORD_BITS-1:0] pos_x,
    input  logic [COORD_BITS-1:0] pos_y,
    input  logic [TAG_BITS-1:0]   finger_tag,
    input  logic [TIME_W-1:0]     now_ms,
    input  logic [THR_W-1:0]      move_slop,
    input  logic [LP_W-1:0]       long_press_ms,
    output logic [CNT_W-1:0]      ent_count,
    output logic [KIND_W-1:0]     ent_kind [MAX_RESULTS],
    output logic [DATA_W-1:0]     ent_data [MAX_RESULTS]
);

    localparam int unsigned C  = COORD_BITS;
    localparam int unsigned DW = COORD_BITS + 1;
    localparam int unsigned FIELD_W = BTN_W + 2 * C + 2 * DW;

    logic            pressing_reg, pressing_next;
    logic            resolved_reg, resolved_next;
    logic            dragging_reg, dragging_next;
    logic [C-1:0]    start_x_reg, start_x_next;
    logic [C-1:0]    start_y_reg, start_y_next;
    logic [TAG_BITS-1:0] start_tag_reg, start_tag_next;
    logic [TIME_W-1:0]   start_time_reg, start_time_next;
    logic [C-1:0]    cursor_x_reg, cursor_x_next;
    logic [C-1:0]    cursor_y_reg, cursor_y_next;

    logic            same;
    logic [C-1:0]    abs_dx, abs_dy;
    logic            drag_hit;
    logic [TIME_W-1:0] elapsed;
    logic            long_hit;
    logic [DW-1:0]   d_px_cur, d_py_cur, d_sx_cur, d_sy_cur, d_px_st, d_py_st;
    logic [DW-1:0]   zero_d;

    function automatic logic [DATA_W-1:0] pack_ent(
        input logic [BTN_W-1:0] btn,
        input logic [C-1:0]     x,
        input logic [C-1:0]     y,
        input logic [DW-1:0]    dx,
        input logic [DW-1:0]    dy
    );
        logic [DATA_W-1:0] v;
        v = '0;
        v[FIELD_W-1:0] = {dy, dx, y, x, btn};
        return v;
    endfunction

    assign zero_d   = '0;
    assign same     = pressing_reg && (finger_tag == start_tag_reg);
    assign abs_dx   = (pos_x >= start_x_reg) ? pos_x - start_x_reg : start_x_reg - pos_x;
    assign abs_dy   = (pos_y >= start_y_reg) ? pos_y - start_y_reg : start_y_reg - pos_y;
    assign drag_hit = (abs_dx > C'(move_slop)) || (abs_dy > C'(move_slop));
    assign elapsed  = now_ms - start_time_reg;
    assign long_hit = elapsed > TIME_W'(long_press_ms);

    assign d_px_cur = {1'b0, pos_x} - {1'b0, cursor_x_reg};
    assign d_py_cur = {1'b0, pos_y} - {1'b0, cursor_y_reg};
    assign d_sx_cur = {1'b0, start_x_reg} - {1'b0, cursor_x_reg};
    assign d_sy_cur = {1'b0, start_y_reg} - {1'b0, cursor_y_reg};
    assign d_px_st  = {1'b0, pos_x} - {1'b0, start_x_reg};
    assign d_py_st  = {1'b0, pos_y} - {1'b0, start_y_reg};

    always_comb begin
        pressing_next   = pressing_reg;
        resolved_next   = resolved_reg;
        dragging_next   = dragging_reg;
        start_x_next    = start_x_reg;
        start_y_next    = start_y_reg;
        start_tag_next  = start_tag_reg;
        start_time_next = start_time_reg;
        cursor_x_next   = cursor_x_reg;
        cursor_y_next   = cursor_y_reg;
        ent_count       = '0;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            ent_kind[i] = KIND_MOVE;
            ent_data[i] = '0;
        end

        case (cmd)
            CMD_DOWN: begin
                if (!pressing_reg) begin
                    pressing_next   = 1'b1;
                    resolved_next   = 1'b0;
                    dragging_next   = 1'b0;
                    start_x_next    = pos_x;
                    start_y_next    = pos_y;
                    start_tag_next  = finger_tag;
                    start_time_next = now_ms;
                    cursor_x_next   = pos_x;
                    cursor_y_next   = pos_y;
                    ent_count       = CNT_W'(1);
                    ent_data[0]     = pack_ent(BTN_NONE, pos_x, pos_y, d_px_cur, d_py_cur);
                end
            end
            CMD_UP: begin
                if (same) begin
                    if (!resolved_reg) begin
                        if (!dragging_reg) begin
                            // tap: move to lift point, then left click there
                            cursor_x_next = pos_x;
                            cursor_y_next = pos_y;
                            ent_count     = CNT_W'(3);
                            ent_data[0]   = pack_ent(BTN_NONE, pos_x, pos_y,
                                                     d_px_cur, d_py_cur);
                            ent_kind[1]   = KIND_BTN_DOWN;
                            ent_data[1]   = pack_ent(BTN_LEFT, pos_x, pos_y, zero_d, zero_d);
                            ent_kind[2]   = KIND_BTN_UP;
                            ent_data[2]   = pack_ent(BTN_LEFT, pos_x, pos_y, zero_d, zero_d);
                        end else begin
                            // end of drag: release at the cursor
                            ent_count   = CNT_W'(1);
                            ent_kind[0] = KIND_BTN_UP;
                            ent_data[0] = pack_ent(BTN_LEFT, cursor_x_reg, cursor_y_reg,
                                                   zero_d, zero_d);
                        end
                    end
                    pressing_next  = 1'b0;
                    resolved_next  = 1'b0;
                    dragging_next  = 1'b0;
                    start_x_next   = '0;
                    start_y_next   = '0;
                    start_tag_next = '0;
                end
            end
            CMD_MOTION: begin
                if (same) begin
                    cursor_x_next = pos_x;
                    cursor_y_next = pos_y;
                    if (!dragging_reg && !resolved_reg && drag_hit) begin
                        // start drag at the press point, then follow the finger
                        dragging_next = 1'b1;
                        ent_count     = CNT_W'(3);
                        ent_data[0]   = pack_ent(BTN_NONE, start_x_reg, start_y_reg,
                                                 d_sx_cur, d_sy_cur);
                        ent_kind[1]   = KIND_BTN_DOWN;
                        ent_data[1]   = pack_ent(BTN_LEFT, start_x_reg, start_y_reg,
                                                 zero_d, zero_d);
                        ent_data[2]   = pack_ent(BTN_NONE, pos_x, pos_y, d_px_st, d_py_st);
                    end else begin
                        ent_count   = CNT_W'(1);
                        ent_data[0] = pack_ent(BTN_NONE, pos_x, pos_y, d_px_cur, d_py_cur);
                    end
                end
            end
            CMD_TICK: begin
                if (pressing_reg && !dragging_reg && !resolved_reg && long_hit) begin
                    // long press: right click at the press point
                    resolved_next = 1'b1;
                    cursor_x_next = start_x_reg;
                    cursor_y_next = start_y_reg;
                    ent_count     = CNT_W'(3);
                    ent_data[0]   = pack_ent(BTN_NONE, start_x_reg, start_y_reg,
                                             d_sx_cur, d_sy_cur);
                    ent_kind[1]   = KIND_BTN_DOWN;
                    ent_data[1]   = pack_ent(BTN_RIGHT, start_x_reg, start_y_reg,
                                             zero_d, zero_d);
                    ent_kind[2]   = KIND_BTN_UP;
                    ent_data[2]   = pack_ent(BTN_RIGHT, start_x_reg, start_y_reg,
                                             zero_d, zero_d);
                end
            end
            default: begin
                ent_count = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pressing_reg   <= 1'b0;
            resolved_reg   <= 1'b0;
            dragging_reg   <= 1'b0;
            start_x_reg    <= '0;
            start_y_reg    <= '0;
            start_tag_reg  <= '0;
            start_time_reg <= '0;
            cursor_x_reg   <= '0;
            cursor_y_reg   <= '0;
        end else if (load) begin
            pressing_reg   <= pressing_next;
            resolved_reg   <= resolved_next;
            dragging_reg   <= dragging_next;
            start_x_reg    <= start_x_next;
            start_y_reg    <= start_y_next;
            start_tag_reg  <= start_tag_next;
            start_time_reg <= start_time_next;
            cursor_x_reg   <= cursor_x_next;
            cursor_y_reg   <= cursor_y_next;
        end
    end

endmodule

### hw/rtl/tgp_res_buf.sv
// Three-entry result buffer that drains one pointer result per cycle while m_tready is high.
module tgp_res_buf
    import tgp_pkg::*;
#(
    parameter int unsigned DATA_W = 48
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  logic [CNT_W-1:0]  ent_count,
    input  logic [KIND_W-1:0] ent_kind [MAX_RESULTS],
    input  logic [DATA_W-1:0] ent_data [MAX_RESULTS],
    output logic              can_load,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,
    output logic [KIND_W-1:0] m_tuser,
    output logic              m_tlast
);

    logic [CNT_W-1:0]  rem_reg;
    logic [KIND_W-1:0] kind_reg [MAX_RESULTS];
    logic [DATA_W-1:0] data_reg [MAX_RESULTS];
    logic              take;

    assign m_tvalid = (rem_reg != '0);
    assign take     = m_tvalid && m_tready;
    // free once the final queued result leaves this cycle
    assign can_load = (rem_reg == '0) || ((rem_reg == CNT_W'(1)) && m_tready);
    assign m_tdata  = data_reg[0];
    assign m_tuser  = kind_reg[0];
    assign m_tlast  = (rem_reg == CNT_W'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
        end else if (load) begin
            rem_reg <= ent_count;
        end else if (take) begin
            rem_reg <= rem_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < MAX_RESULTS; i++) begin
                kind_reg[i] <= ent_kind[i];
                data_reg[i] <= ent_data[i];
            end
        end else if (take) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                kind_reg[i] <= kind_reg[i+1];
                data_reg[i] <= data_reg[i+1];
            end
        end
    end

endmodule

### hw/rtl/touch_gesture_to_pointer_unit.sv
// Top level of the touch gesture to pointer unit.
// Converts single-finger touch transactions (down, up, motion, time tick) into
// pointer transactions: moves, left clicks, left drags and long-press right
// clicks. A touch transaction is captured in an input register, decoded against
// the gesture state in one pass, and its results (zero to three) land in a
// three-entry result buffer that presents one result per cycle on the m_ side
// while m_tready is high, tlast marking the final result of each input that
// gives any. The held transaction is decoded once the result buffer can take
// it, and its first result is then offered from the result buffer. Throughput
// is one input per cycle for inputs that give at most one result, while
// m_tready is high; an input giving three results holds the buffer until all
// three have left, so the drain rate of the result buffer sets the sustained
// rate. While results wait, the input register takes one more transaction and
// then s_tready drops until the buffer frees; the input register parts the two
// sides. Write move_slop and long_press_ms through the cfg_ port only while no
// transaction is in flight; a write lands at the clock edge where cfg_wr_en is
// high. Elapsed press time is taken modulo 2^32 of now_ms.
module touch_gesture_to_pointer_unit
    import tgp_pkg::*;
#(
    parameter int unsigned COORD_BITS = 10,
    parameter int unsigned TAG_BITS   = 8,
    localparam int unsigned S_DATA_W  = ((2 * COORD_BITS + TAG_BITS + TIME_W) + 7) / 8 * 8,
    localparam int unsigned M_DATA_W  = ((BTN_W + 4 * COORD_BITS + 2) + 7) / 8 * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // touch input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,  // pos_x, pos_y, finger_tag, now_ms, zero pad
    input  logic [CMD_W-1:0]      s_tuser,  // cmd
    // pointer output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,  // button_mask, out_x, out_y, delta_x, delta_y, pad
    output logic [KIND_W-1:0]     m_tuser,  // kind
    output logic                  m_tlast
);

    localparam int unsigned C = COORD_BITS;

    logic [THR_W-1:0]      move_slop_reg;
    logic [LP_W-1:0]       long_press_ms_reg;

    logic                  in_valid_reg;
    logic [CMD_W-1:0]      cmd_reg;
    logic [C-1:0]          pos_x_reg;
    logic [C-1:0]          pos_y_reg;
    logic [TAG_BITS-1:0]   tag_reg;
    logic [TIME_W-1:0]     now_reg;

    logic                  can_load;
    logic                  load;
    logic [CNT_W-1:0]      ent_count;
    logic [KIND_W-1:0]     ent_kind [MAX_RESULTS];
    logic [M_DATA_W-1:0]   ent_data [MAX_RESULTS];

    // Decode the held transaction once the result buffer has room for it.
    assign load     = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || load;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            move_slop_reg     <= MOVE_SLOP_RST;
            long_press_ms_reg <= LONG_PRESS_MS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MOVE_SLOP:     move_slop_reg     <= cfg_wdata[THR_W-1:0];
                CFG_LONG_PRESS_MS: long_press_ms_reg <= cfg_wdata[LP_W-1:0];
                default: begin
                    move_slop_reg <= move_slop_reg;
                end
            endcase
        end
    end

    // Input register: hold a touch transaction until the decode takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg   <= s_tuser;
            pos_x_reg <= s_tdata[C-1:0];
            pos_y_reg <= s_tdata[2*C-1:C];
            tag_reg   <= s_tdata[2*C+TAG_BITS-1:2*C];
            now_reg   <= s_tdata[2*C+TAG_BITS+TIME_W-1:2*C+TAG_BITS];
        end
    end

    tgp_core #(
        .COORD_BITS (COORD_BITS),
        .TAG_BITS   (TAG_BITS),
        .DATA_W     (M_DATA_W)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (load),
        .cmd            (cmd_reg),
        .pos_x          (pos_x_reg),
        .pos_y          (pos_y_reg),
        .finger_tag     (tag_reg),
        .now_ms         (now_reg),
        .move_slop      (move_slop_reg),
        .long_press_ms  (long_press_ms_reg),
        .ent_count      (ent_count),
        .ent_kind       (ent_kind),
        .ent_data       (ent_data)
    );

    tgp_res_buf #(
        .DATA_W (M_DATA_W)
    ) u_res_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .ent_count (ent_count),
        .ent_kind  (ent_kind),
        .ent_data  (ent_data),
        .can_load  (can_load),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
